// ===== src/ctsut_pkg.sv =====
// types, constants and tables shared by the local time to unix time converter
package ctsut_pkg;

  typedef logic        [13:0] year_t;
  typedef logic        [3:0]  month_t;
  typedef logic        [4:0]  day_t;
  typedef logic        [4:0]  hour_t;
  typedef logic        [5:0]  minute_t;
  typedef logic        [5:0]  second_t;
  typedef logic signed [7:0]  tz_t;
  typedef logic        [7:0]  dst_t;
  typedef logic signed [38:0] unix_time_t;
  typedef logic signed [13:0] offset_t;
  typedef logic signed [10:0] manual_offset_t;

  localparam year_t       YEAR_MIN     = 14'd1970;
  localparam year_t       YEAR_MAX     = 14'd9999;
  localparam month_t      MONTH_MIN    = 4'd1;
  localparam month_t      MONTH_MAX    = 4'd12;
  localparam logic [7:0]  ZONE_UNKNOWN = 8'h80;
  localparam dst_t        DST_UNKNOWN  = 8'hFF;
  localparam int          QUARTER_MIN  = 15;
  localparam int          SECS_PER_DAY = 86400;
  localparam int          SECS_PER_HR  = 3600;
  localparam int          SECS_PER_MIN = 60;

  // floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT for n below 43699
  localparam int          RECIP_100    = 5243;
  localparam int          RECIP_SHIFT  = 19;

  function automatic logic [8:0] days_before_month(input month_t mo);
    logic [8:0] d;
    case (mo)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/ctsut_ifs.sv =====
// valid/ready channel interfaces for input, result and configuration transactions
interface ctsut_in_if;
  import ctsut_pkg::*;
  logic    valid;
  logic    ready;
  year_t   year;
  month_t  month;
  day_t    day;
  hour_t   hour;
  minute_t minute;
  second_t second;
  logic    local_info_ok;
  tz_t     tz_quarter_hours;
  dst_t    dst_code;

  modport source (
    output valid, year, month, day, hour, minute, second,
           local_info_ok, tz_quarter_hours, dst_code,
    input  ready
  );
  modport sink (
    input  valid, year, month, day, hour, minute, second,
           local_info_ok, tz_quarter_hours, dst_code,
    output ready
  );
endinterface

interface ctsut_out_if;
  import ctsut_pkg::*;
  logic       valid;
  logic       ready;
  unix_time_t unix_time;
  offset_t    offset_applied;
  logic       offset_detected;

  modport source (
    output valid, unix_time, offset_applied, offset_detected,
    input  ready
  );
  modport sink (
    input  valid, unix_time, offset_applied, offset_detected,
    output ready
  );
endinterface

interface ctsut_cfg_if;
  import ctsut_pkg::*;
  logic           valid;
  logic           ready;
  manual_offset_t manual_offset_minutes;

  modport source (
    output valid, manual_offset_minutes,
    input  ready
  );
  modport sink (
    input  valid, manual_offset_minutes,
    output ready
  );
endinterface

// ===== src/cts_local_time_to_unix_epoch_unit.sv =====
// local wall-clock time to utc unix time converter, four-stage pipeline
//
// in_ch takes one local time transaction (calendar fields plus the optional
// zone and daylight bytes); out_ch gives the utc unix time, the offset in
// minutes that was subtracted and whether it came from the zone bytes or
// from the manual offset register. cfg_ch writes the manual offset; it is
// always ready and should only be written while no transaction is in flight.
// four register stages: clamp and reciprocal multiplies, day count, days
// times 86400, final add. an accepted transaction passes through them in order
// to out_ch. throughput: one transaction per cycle while out_ch.ready is high.
// each stage holds a valid bit; a stage loads when it is empty or the stage
// after it moves, so a stalled receiver backs up the pipe one stage at a
// time and nothing is dropped or repeated; in_ch.ready falls only when all
// four stages are full and out_ch.ready is low.
// reset clears all valid bits and sets the manual offset to zero.
module cts_local_time_to_unix_epoch_unit (
  input logic   clk,
  input logic   rst_n,
  ctsut_in_if.sink    in_ch,
  ctsut_out_if.source out_ch,
  ctsut_cfg_if.sink   cfg_ch
);
  import ctsut_pkg::*;

  // configuration
  manual_offset_t manual_off_r;

  // pipeline valid bits and stage enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1
  year_t       y1_r,   y1_nxt;
  month_t      mo1_r,  mo1_nxt;
  day_t        d1_r;
  hour_t       h1_r;
  minute_t     mi1_r;
  second_t     s1_r;
  offset_t     off1_r, off1_nxt;
  logic        det1_r, det1_nxt;
  logic [25:0] p100_r, p100_nxt;
  logic [23:0] p400_r, p400_nxt;
  logic [25:0] py_r,   py_nxt;
  logic [12:0] n100;
  logic [11:0] n400;
  logic [13:0] n1601;
  offset_t     off_tz, off_dst;

  // stage 2
  logic signed [23:0] days2_r, days2_nxt;
  logic signed [20:0] secs2_r, secs2_nxt;
  offset_t            off2_r;
  logic               det2_r;
  logic [6:0]         q100, qy;
  logic [4:0]         q400;
  logic [12:0]        yo;
  logic [13:0]        yo1;
  logic [13:0]        cent;
  logic               leap;
  logic [22:0]        pos;
  logic [16:0]        hms;

  // stage 3
  logic signed [39:0] prod3_r, prod3_nxt;
  logic signed [20:0] secs3_r;
  offset_t            off3_r;
  logic               det3_r;

  // stage 4 (output register)
  unix_time_t unix4_r, unix4_nxt;
  offset_t    off4_r;
  logic       det4_r;

  // handshake and stage enables
  assign rdy4        = !v4_r || out_ch.ready;
  assign rdy3        = !v3_r || rdy4;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      manual_off_r <= '0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (cfg_ch.valid && cfg_ch.ready) manual_off_r <= cfg_ch.manual_offset_minutes;
    end
  end

  // stage 1: clamps, offset select, reciprocal products
  always_comb begin
    if (in_ch.year < YEAR_MIN) begin
      y1_nxt = YEAR_MIN;
    end else if (in_ch.year > YEAR_MAX) begin
      y1_nxt = YEAR_MAX;
    end else begin
      y1_nxt = in_ch.year;
    end
    if (in_ch.month < MONTH_MIN) begin
      mo1_nxt = MONTH_MIN;
    end else if (in_ch.month > MONTH_MAX) begin
      mo1_nxt = MONTH_MAX;
    end else begin
      mo1_nxt = in_ch.month;
    end

    n100  = 13'(y1_nxt - 14'd1901);
    n1601 = y1_nxt - 14'd1601;
    n400  = n1601[13:2];
    p100_nxt = 26'(n100) * 26'(RECIP_100);
    p400_nxt = 24'(n400) * 24'(RECIP_100);
    py_nxt   = 26'(y1_nxt) * 26'(RECIP_100);

    off_tz  = 14'(in_ch.tz_quarter_hours) * 14'(QUARTER_MIN);
    off_dst = (in_ch.dst_code != DST_UNKNOWN) ?
              $signed(14'(in_ch.dst_code)) * 14'(QUARTER_MIN) : '0;
    det1_nxt = in_ch.local_info_ok && ($unsigned(in_ch.tz_quarter_hours) != ZONE_UNKNOWN);
    off1_nxt = det1_nxt ? (off_tz + off_dst) : 14'(manual_off_r);
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      y1_r   <= y1_nxt;
      mo1_r  <= mo1_nxt;
      d1_r   <= in_ch.day;
      h1_r   <= in_ch.hour;
      mi1_r  <= in_ch.minute;
      s1_r   <= in_ch.second;
      off1_r <= off1_nxt;
      det1_r <= det1_nxt;
      p100_r <= p100_nxt;
      p400_r <= p400_nxt;
      py_r   <= py_nxt;
    end
  end

  // stage 2: day count and seconds of day less the offset
  always_comb begin
    q100 = p100_r[RECIP_SHIFT +: 7];
    q400 = p400_r[RECIP_SHIFT +: 5];
    qy   = py_r[RECIP_SHIFT +: 7];
    cent = 14'(qy) * 14'd100;
    leap = (y1_r[1:0] == 2'b00) && ((y1_r != cent) || (qy[1:0] == 2'b00));
    yo   = 13'(y1_r - YEAR_MIN);
    yo1  = 14'(yo) + 14'd1;
    pos  = 23'(yo) * 23'd365 + 23'(yo1[13:2]) - 23'(q100) + 23'(q400)
         + 23'(days_before_month(mo1_r)) + 23'((mo1_r > 4'd2) && leap) + 23'(d1_r);
    days2_nxt = $signed(24'(pos)) - 24'sd1;
    hms  = 17'(h1_r) * 17'(SECS_PER_HR) + 17'(mi1_r) * 17'(SECS_PER_MIN) + 17'(s1_r);
    secs2_nxt = $signed(21'(hms)) - 21'(off1_r) * 21'(SECS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      days2_r <= days2_nxt;
      secs2_r <= secs2_nxt;
      off2_r  <= off1_r;
      det2_r  <= det1_r;
    end
  end

  // stage 3: days to seconds
  assign prod3_nxt = 40'(days2_r) * 40'(SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      prod3_r <= prod3_nxt;
      secs3_r <= secs2_r;
      off3_r  <= off2_r;
      det3_r  <= det2_r;
    end
  end

  // stage 4: final sum into the output register
  assign unix4_nxt = 39'(prod3_r + 40'(secs3_r));

  always_ff @(posedge clk) begin
    if (rdy4) begin
      unix4_r <= unix4_nxt;
      off4_r  <= off3_r;
      det4_r  <= det3_r;
    end
  end

  assign out_ch.valid           = v4_r;
  assign out_ch.unix_time       = unix4_r;
  assign out_ch.offset_applied  = off4_r;
  assign out_ch.offset_detected = det4_r;

  // checks
  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v1_r)
    else $error("accepted transaction did not reach stage 1");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r && v4_r && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

  a_manual_offset_used: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.offset_detected) |->
      (out_ch.offset_applied == 14'(manual_off_r)))
    else $error("fallback offset differs from manual register");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.offset_applied >= -14'sd1920) &&
                      (out_ch.offset_applied <= 14'sd5715)))
    else $error("offset out of range");

endmodule

// ===== dv/tb_cts_local_time_to_unix_epoch_unit.sv =====
// testbench for the local time to utc unix time converter, checked against a built-in model
`timescale 1ns / 100ps

module tb_cts_local_time_to_unix_epoch_unit;
  import ctsut_pkg::*;

  localparam int PIPE_DEPTH   = 4;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
    second_t second;
    logic    local_info_ok;
    tz_t     tz_quarter_hours;
    dst_t    dst_code;
  } local_time_t;

  typedef struct packed {
    unix_time_t unix_time;
    offset_t    offset_applied;
    logic       offset_detected;
  } utc_result_t;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   error_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  manual_offset_t manual_offset_shadow = '0;
  utc_result_t    expected_utc[$];

  ctsut_in_if  in_ch ();
  ctsut_out_if out_ch ();
  ctsut_cfg_if cfg_ch ();

  cts_local_time_to_unix_epoch_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[cts_local_time_to_unix_epoch_unit] ERROR");
      $finish;
    end
  end

  function automatic utc_result_t convert_local_time(local_time_t lt, manual_offset_t manual);
    utc_result_t r;
    longint      y;
    longint      mo;
    longint      days;
    longint      secs;
    longint      ofs;
    longint      utc;
    bit          leap;
    y  = lt.year;
    mo = lt.month;
    if (y < 1970) y = 1970;
    if (y > 9999) y = 9999;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    days = 365 * (y - 1970) + (y - 1969) / 4 - (y - 1901) / 100 + (y - 1601) / 400;
    for (int m = 1; m < mo; m++) begin
      if (m == 2) days += 28;
      else if (m == 4 || m == 6 || m == 9 || m == 11) days += 30;
      else days += 31;
    end
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (mo > 2 && leap) days += 1;
    days += longint'(lt.day) - 1;
    secs = days * 86400 + longint'(lt.hour) * 3600 + longint'(lt.minute) * 60
         + longint'(lt.second);
    if (lt.local_info_ok && lt.tz_quarter_hours != ZONE_UNKNOWN) begin
      ofs = longint'(lt.tz_quarter_hours) * 15;
      if (lt.dst_code != DST_UNKNOWN) ofs += longint'(lt.dst_code) * 15;
      r.offset_detected = 1'b1;
    end else begin
      ofs = longint'(manual);
      r.offset_detected = 1'b0;
    end
    utc = secs - ofs * 60;
    r.unix_time      = utc[38:0];
    r.offset_applied = ofs[13:0];
    return r;
  endfunction

  function automatic local_time_t make_time(int yr, int mo, int dy, int hr, int mi, int sc,
                                            bit ok, int tz, int dst);
    local_time_t lt;
    lt.year             = year_t'(yr);
    lt.month            = month_t'(mo);
    lt.day              = day_t'(dy);
    lt.hour             = hour_t'(hr);
    lt.minute           = minute_t'(mi);
    lt.second           = second_t'(sc);
    lt.local_info_ok    = ok;
    lt.tz_quarter_hours = tz_t'(tz);
    lt.dst_code         = dst_t'(dst);
    return lt;
  endfunction

  function automatic local_time_t random_local_time();
    local_time_t lt;
    int          shape;
    int          pick;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      lt = make_time($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
                     $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255));
    end else begin
      lt = make_time(shape < 4 ? $urandom_range(1970, 9999) : $urandom_range(1970, 2100),
                     $urandom_range(1, 12),
                     shape < 7 ? $urandom_range(1, 28) : $urandom_range(1, 31),
                     $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                     $urandom_range(0, 9) != 0, 0, 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) lt.tz_quarter_hours = tz_t'(ZONE_UNKNOWN);
      else if (pick == 1) lt.tz_quarter_hours = tz_t'($urandom_range(0, 255));
      else lt.tz_quarter_hours = tz_t'(int'($urandom_range(0, 104)) - 48);
      pick = $urandom_range(0, 9);
      if (pick < 4) lt.dst_code = '0;
      else if (pick < 6) lt.dst_code = dst_t'(4);
      else if (pick < 8) lt.dst_code = DST_UNKNOWN;
      else lt.dst_code = dst_t'($urandom_range(0, 255));
    end
    return lt;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // result monitor and receiver stalls
  always @(posedge clk) begin
    utc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_utc.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction unix_time %0d",
                                  longint'(out_ch.unix_time)));
      end else begin
        want = expected_utc.pop_front();
        if (out_ch.unix_time !== want.unix_time)
          report_mismatch($sformatf("unix_time got %0d expected %0d",
                                    longint'(out_ch.unix_time), longint'(want.unix_time)));
        if (out_ch.offset_applied !== want.offset_applied)
          report_mismatch($sformatf("offset_applied got %0d expected %0d",
                                    longint'(out_ch.offset_applied),
                                    longint'(want.offset_applied)));
        if (out_ch.offset_detected !== want.offset_detected)
          report_mismatch($sformatf("offset_detected got %b expected %b",
                                    out_ch.offset_detected, want.offset_detected));
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_local_time(local_time_t lt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.year             <= lt.year;
    in_ch.month            <= lt.month;
    in_ch.day              <= lt.day;
    in_ch.hour             <= lt.hour;
    in_ch.minute           <= lt.minute;
    in_ch.second           <= lt.second;
    in_ch.local_info_ok    <= lt.local_info_ok;
    in_ch.tz_quarter_hours <= lt.tz_quarter_hours;
    in_ch.dst_code         <= lt.dst_code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_utc.push_back(convert_local_time(lt, manual_offset_shadow));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_utc.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_manual_offset(manual_offset_t value);
    wait_idle();
    cfg_ch.valid                 <= 1'b1;
    cfg_ch.manual_offset_minutes <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid         <= 1'b0;
    manual_offset_shadow = value;
  endtask

  task automatic test_calendar_extremes();
    send_local_time(make_time(0, 1, 1, 0, 0, 0, 0, 0, 0));
    send_local_time(make_time(1969, 12, 31, 23, 59, 59, 0, 0, 0));
    send_local_time(make_time(1970, 1, 1, 0, 0, 0, 0, 0, 0));
    send_local_time(make_time(9999, 12, 31, 23, 59, 59, 0, 0, 0));
    send_local_time(make_time(16383, 15, 31, 31, 63, 63, 1, 127, 254));
    send_local_time(make_time(2000, 3, 1, 12, 0, 0, 0, 0, 0));
    send_local_time(make_time(2100, 3, 1, 12, 0, 0, 0, 0, 0));
    send_local_time(make_time(2024, 2, 29, 6, 30, 15, 0, 0, 0));
    send_local_time(make_time(2023, 0, 0, 0, 0, 0, 0, 0, 0));
    send_local_time(make_time(2023, 13, 1, 0, 0, 0, 0, 0, 0));
    send_local_time(make_time(2023, 2, 31, 24, 60, 60, 0, 0, 0));
    send_local_time(make_time(10000, 6, 15, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_zone_and_dst();
    send_local_time(make_time(2030, 7, 4, 10, 0, 0, 1, 127, 254));
    send_local_time(make_time(2030, 7, 4, 10, 0, 0, 1, -127, 0));
    send_local_time(make_time(2030, 7, 4, 10, 0, 0, 1, -128, 4));
    send_local_time(make_time(2030, 7, 4, 10, 0, 0, 0, 36, 4));
    send_local_time(make_time(2030, 7, 4, 10, 0, 0, 1, 4, 255));
    send_local_time(make_time(2030, 7, 4, 10, 0, 0, 1, 0, 4));
  endtask

  task automatic test_manual_offset();
    manual_offset_t settings[4];
    settings = '{-11'sd720, 11'sd840, manual_offset_t'(-1024), 11'sd1023};
    foreach (settings[i]) begin
      write_manual_offset(settings[i]);
      send_local_time(make_time(1970, 1, 1, 0, 0, 0, bit'(i % 2), -128, 0));
    end
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count);
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_manual_offset(manual_offset_t'($urandom_range(0, 2047)));
    repeat (count) send_local_time(random_local_time());
  endtask

  initial begin
    rst_n                        <= 1'b0;
    in_ch.valid                  <= 1'b0;
    in_ch.year                   <= '0;
    in_ch.month                  <= '0;
    in_ch.day                    <= '0;
    in_ch.hour                   <= '0;
    in_ch.minute                 <= '0;
    in_ch.second                 <= '0;
    in_ch.local_info_ok          <= 1'b0;
    in_ch.tz_quarter_hours       <= '0;
    in_ch.dst_code               <= '0;
    cfg_ch.valid                 <= 1'b0;
    cfg_ch.manual_offset_minutes <= '0;
    send_idle_pct = 14;
    recv_idle_pct = 62;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_calendar_extremes();
    test_zone_and_dst();
    test_manual_offset();
    test_random_traffic(14, 62, 270);
    test_random_traffic(62, 14, 265);
    test_random_traffic(0, 0, 265);

    wait_idle();
    repeat (PIPE_DEPTH * 2) @(posedge clk);
    if (error_count == 0) begin
      $display("[cts_local_time_to_unix_epoch_unit] OK");
    end else begin
      $display("[cts_local_time_to_unix_epoch_unit] ERROR");
    end
    $finish;
  end

endmodule
